@@ src/tx_rx_relay_sequencer_defines.svh @@
`ifndef TX_RX_RELAY_SEQUENCER_DEFINES_SVH
`define TX_RX_RELAY_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define TRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/trs_pkg.sv @@
package trs_pkg;

  localparam int unsigned MAX_STEPS = 4;
  localparam int unsigned RES_CAP   = 2 * MAX_STEPS + 1;
  localparam int unsigned CNT_W     = $clog2(RES_CAP + 1);
  localparam int unsigned IDX_W     = $clog2(RES_CAP);

  localparam logic [2:0] ACT_TICK     = 3'd0;
  localparam logic [2:0] ACT_PTT_ON   = 3'd1;
  localparam logic [2:0] ACT_PTT_OFF  = 3'd2;
  localparam logic [2:0] ACT_FAULT    = 3'd3;
  localparam logic [2:0] ACT_CLEAR    = 3'd4;

  localparam logic [2:0] MODE_RX      = 3'd0;
  localparam logic [2:0] MODE_SEQ_TX  = 3'd1;
  localparam logic [2:0] MODE_TX      = 3'd2;
  localparam logic [2:0] MODE_SEQ_RX  = 3'd3;
  localparam logic [2:0] MODE_FAULT   = 3'd4;

  localparam logic [2:0] FAULT_NONE   = 3'd0;
  localparam logic [2:0] FAULT_EMERG  = 3'd4;

  localparam logic [2:0] REG_PA_RELAY = 3'd0;
  localparam logic [2:0] REG_TX_LOW   = 3'd1;
  localparam logic [2:0] REG_TX_HIGH  = 3'd2;
  localparam logic [2:0] REG_RX_LOW   = 3'd3;
  localparam logic [2:0] REG_RX_HIGH  = 3'd4;
  localparam logic [2:0] REG_TX_COUNT = 3'd5;
  localparam logic [2:0] REG_RX_COUNT = 3'd6;

  localparam logic [2:0] UPC_FETCH    = 3'd0;
  localparam logic [2:0] UPC_DECODE   = 3'd1;
  localparam logic [2:0] UPC_ADV_TEST = 3'd2;
  localparam logic [2:0] UPC_ADV_STEP = 3'd3;
  localparam logic [2:0] UPC_EMIT     = 3'd7;

  typedef enum logic [3:0] {
    RUN_IDLE = 4'b0001,
    RUN_TX   = 4'b0010,
    RUN_RX   = 4'b0100,
    RUN_SAFE = 4'b1000
  } run_t;

  typedef enum logic [1:0] {
    UOP_NONE    = 2'd0,
    UOP_DECODE  = 2'd1,
    UOP_ADVANCE = 2'd2,
    UOP_EMIT    = 2'd3
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_ITEM   = 3'd2,
    COND_ADV_DONE  = 3'd3,
    COND_EMIT_MORE = 3'd4
  } cond_t;

  typedef struct packed {
    uop_t       op;
    cond_t      cond;
    logic [2:0] target;
  } uword_t;

  typedef struct packed {
    uop_t op;
    logic accept;
  } trs_ctrl_t;

  typedef struct packed {
    logic adv_done;
    logic emit_more;
  } trs_stat_t;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] fault_kind;
    logic       ptt_level;
  } trs_in_t;

  typedef struct packed {
    logic       relay_valid;
    logic [3:0] relay_num;
    logic       relay_on;
    logic [2:0] mode;
    logic [2:0] latched_fault;
    logic       clear_rejected;
    logic       last;
  } trs_out_t;

endpackage

@@ src/trs_ucode.sv @@
module trs_ucode
  import trs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  trs_stat_t stat,
  output trs_ctrl_t ctrl,
  output logic      in_stall
);

  logic [2:0] pc_r, pc_nxt;
  uword_t     uw;
  logic       taken;

  // EMIT sits at the top address so its fall-through wraps to FETCH
  function automatic uword_t rom(input logic [2:0] a);
    uword_t w;
    w = '{op: UOP_NONE, cond: COND_ALWAYS, target: UPC_FETCH};
    unique case (a)
      UPC_FETCH:    w = '{op: UOP_NONE,    cond: COND_NO_ITEM,   target: UPC_FETCH};
      UPC_DECODE:   w = '{op: UOP_DECODE,  cond: COND_NEVER,     target: UPC_FETCH};
      UPC_ADV_TEST: w = '{op: UOP_NONE,    cond: COND_ADV_DONE,  target: UPC_EMIT};
      UPC_ADV_STEP: w = '{op: UOP_ADVANCE, cond: COND_ALWAYS,    target: UPC_ADV_TEST};
      UPC_EMIT:     w = '{op: UOP_EMIT,    cond: COND_EMIT_MORE, target: UPC_EMIT};
      default:      w = '{op: UOP_NONE,    cond: COND_ALWAYS,    target: UPC_FETCH};
    endcase
    return w;
  endfunction

  assign uw = rom(pc_r);

  always_comb begin
    unique case (uw.cond)
      COND_NEVER:     taken = 1'b0;
      COND_ALWAYS:    taken = 1'b1;
      COND_NO_ITEM:   taken = !in_valid;
      COND_ADV_DONE:  taken = stat.adv_done;
      COND_EMIT_MORE: taken = stat.emit_more;
      default:        taken = 1'b1;
    endcase
  end

  assign pc_nxt      = taken ? uw.target : pc_r + 3'd1;
  assign in_stall    = (pc_r != UPC_FETCH);
  assign ctrl.op     = uw.op;
  assign ctrl.accept = (pc_r == UPC_FETCH) && in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UPC_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ src/trs_datapath.sv @@
module trs_datapath
  import trs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  trs_ctrl_t   ctrl,
  input  trs_in_t     in_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        out_stall,
  output logic        out_valid,
  output trs_out_t    out_data,
  output trs_stat_t   stat
);

  `include "tx_rx_relay_sequencer_defines.svh"

  // configuration
  logic [3:0]  pa_relay_r;
  logic [63:0] tx_lo_r, tx_hi_r, rx_lo_r, rx_hi_r;
  logic [2:0]  tx_cnt_r, rx_cnt_r;

  // sequencer state
  logic [2:0]  mode_r, mode_nxt;
  logic [2:0]  fault_r, fault_nxt;
  run_t        run_r, run_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic        rej_r, rej_nxt;

  // latched item
  logic [2:0]  act_r;
  logic [2:0]  code_r;
  logic        ptt_r;
  logic [2:0]  code_fix;

  // write buffer
  logic [4:0]       wbuf_r [RES_CAP];
  logic [CNT_W-1:0] wcnt_r, wcnt_nxt, wbase;
  logic [CNT_W-1:0] rd_r;
  logic             wr_en;
  logic [3:0]       wr_id;
  logic             wr_on;

  // output register
  logic       out_valid_r;
  trs_out_t   out_r;
  logic       out_free, emit_last;
  logic [CNT_W-1:0] n_words;

  logic        idle, is_tx;
  logic [2:0]  used;
  logic [63:0] tbl_reg;
  logic [31:0] sw;

  function automatic logic [2:0] sat_steps(input logic [2:0] c);
    return (c > 3'(MAX_STEPS)) ? 3'(MAX_STEPS) : c;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_relay_r <= '0;
      tx_lo_r    <= '0;
      tx_hi_r    <= '0;
      rx_lo_r    <= '0;
      rx_hi_r    <= '0;
      tx_cnt_r   <= '0;
      rx_cnt_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PA_RELAY: pa_relay_r <= cfg_data[3:0];
        REG_TX_LOW:   tx_lo_r    <= cfg_data;
        REG_TX_HIGH:  tx_hi_r    <= cfg_data;
        REG_RX_LOW:   rx_lo_r    <= cfg_data;
        REG_RX_HIGH:  rx_hi_r    <= cfg_data;
        REG_TX_COUNT: tx_cnt_r   <= cfg_data[2:0];
        REG_RX_COUNT: rx_cnt_r   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign code_fix = (in_data.fault_kind == 3'd0 || in_data.fault_kind > FAULT_EMERG)
                    ? FAULT_EMERG : in_data.fault_kind;

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      act_r  <= in_data.action;
      code_r <= code_fix;
      ptt_r  <= in_data.ptt_level;
    end
  end

  assign idle    = (run_r == RUN_IDLE);
  assign is_tx   = (run_r == RUN_TX);
  assign used    = sat_steps(is_tx ? tx_cnt_r : rx_cnt_r);
  assign tbl_reg = is_tx ? (step_r[1] ? tx_hi_r : tx_lo_r)
                         : (step_r[1] ? rx_hi_r : rx_lo_r);
  assign sw      = step_r[0] ? tbl_reg[63:32] : tbl_reg[31:0];

  always_comb begin
    mode_nxt  = mode_r;
    fault_nxt = fault_r;
    run_nxt   = run_r;
    step_nxt  = step_r;
    delay_nxt = delay_r;
    pend_nxt  = pend_r;
    rej_nxt   = rej_r;
    wr_en     = 1'b0;
    wr_id     = pa_relay_r;
    wr_on     = 1'b0;
    wbase     = wcnt_r;
    unique case (ctrl.op)
      UOP_DECODE: begin
        wbase   = '0;
        rej_nxt = 1'b0;
        unique case (act_r)
          ACT_TICK: begin
            if (!idle && delay_r != '0) begin
              delay_nxt = delay_r - 16'd1;
            end
          end
          ACT_PTT_ON: begin
            if (idle && mode_r == MODE_RX) begin
              run_nxt   = RUN_TX;
              step_nxt  = '0;
              delay_nxt = '0;
              mode_nxt  = MODE_SEQ_TX;
            end
          end
          ACT_PTT_OFF: begin
            if (idle && mode_r == MODE_TX) begin
              run_nxt   = RUN_RX;
              step_nxt  = '0;
              delay_nxt = '0;
              mode_nxt  = MODE_SEQ_RX;
            end
          end
          ACT_FAULT: begin
            if (idle) begin
              if (mode_r != MODE_FAULT) begin
                pend_nxt  = code_r;
                wr_en     = 1'b1;
                run_nxt   = RUN_SAFE;
                step_nxt  = '0;
                delay_nxt = '0;
              end
            end else if (run_r != RUN_SAFE && pend_r == FAULT_NONE) begin
              pend_nxt = code_r;
            end
          end
          ACT_CLEAR: begin
            if (idle && mode_r == MODE_FAULT) begin
              pend_nxt  = FAULT_NONE;
              run_nxt   = RUN_SAFE;
              step_nxt  = '0;
              delay_nxt = '0;
            end else begin
              rej_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      UOP_ADVANCE: begin
        if ((run_r == RUN_TX || run_r == RUN_RX) && pend_r != FAULT_NONE) begin
          // pending fault at a step boundary: PA off, then safe RX run
          wr_en     = 1'b1;
          run_nxt   = RUN_SAFE;
          step_nxt  = '0;
          delay_nxt = '0;
        end else if (step_r < used) begin
          wr_en     = 1'b1;
          wr_id     = sw[3:0];
          wr_on     = sw[4];
          delay_nxt = sw[31:16];
          step_nxt  = step_r + 3'd1;
        end else begin
          step_nxt = '0;
          priority case (1'b1)
            run_r == RUN_TX: begin
              if (ptt_r) begin
                mode_nxt = MODE_TX;
                run_nxt  = RUN_IDLE;
              end else begin
                run_nxt   = RUN_RX;
                delay_nxt = '0;
                mode_nxt  = MODE_SEQ_RX;
              end
            end
            run_r == RUN_RX: begin
              if (!ptt_r) begin
                mode_nxt = MODE_RX;
                run_nxt  = RUN_IDLE;
              end else begin
                run_nxt   = RUN_TX;
                delay_nxt = '0;
                mode_nxt  = MODE_SEQ_TX;
              end
            end
            default: begin
              if (pend_r != FAULT_NONE) begin
                fault_nxt = pend_r;
                mode_nxt  = MODE_FAULT;
              end else begin
                fault_nxt = FAULT_NONE;
                mode_nxt  = MODE_RX;
              end
              pend_nxt = FAULT_NONE;
              run_nxt  = RUN_IDLE;
            end
          endcase
        end
      end
      default: ;
    endcase
    wcnt_nxt = wbase;
    if (wr_en && wbase < CNT_W'(RES_CAP)) begin
      wcnt_nxt = wbase + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RX;
      fault_r <= FAULT_NONE;
      run_r   <= RUN_IDLE;
      step_r  <= '0;
      delay_r <= '0;
      pend_r  <= FAULT_NONE;
      rej_r   <= 1'b0;
      wcnt_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      fault_r <= fault_nxt;
      run_r   <= run_nxt;
      step_r  <= step_nxt;
      delay_r <= delay_nxt;
      pend_r  <= pend_nxt;
      rej_r   <= rej_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wbase < CNT_W'(RES_CAP)) begin
      wbuf_r[wbase[IDX_W-1:0]] <= {wr_id, wr_on};
    end
  end

  // result words
  assign n_words   = (wcnt_r == '0) ? CNT_W'(1) : wcnt_r;
  assign emit_last = (rd_r + CNT_W'(1) == n_words);
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rd_r        <= '0;
    end else begin
      if (ctrl.op == UOP_DECODE) begin
        rd_r <= '0;
      end else if (ctrl.op == UOP_EMIT && out_free) begin
        rd_r <= rd_r + CNT_W'(1);
      end
      if (ctrl.op == UOP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == UOP_EMIT && out_free) begin
      out_r.relay_valid    <= (wcnt_r != '0);
      out_r.relay_num      <= (wcnt_r != '0) ? wbuf_r[rd_r[IDX_W-1:0]][4:1] : 4'd0;
      out_r.relay_on       <= (wcnt_r != '0) ? wbuf_r[rd_r[IDX_W-1:0]][0] : 1'b0;
      out_r.mode           <= mode_r;
      out_r.latched_fault  <= fault_r;
      out_r.clear_rejected <= rej_r;
      out_r.last           <= emit_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_r;
  assign stat.adv_done  = idle || (delay_r != '0);
  assign stat.emit_more = !(out_free && emit_last);

  `TRS_ASSERT_NOW(a_wait_between_items, ctrl.accept && run_r != RUN_IDLE, delay_r != '0,
                  "active run accepted an item without a pending delay")
  `TRS_ASSERT_NOW(a_fault_mode_match, run_r == RUN_IDLE,
                  (mode_r == MODE_FAULT) == (fault_r != FAULT_NONE),
                  "fault mode and latched fault disagree")
  `TRS_ASSERT_NOW(a_run_mode_match, run_r == RUN_TX || run_r == RUN_RX,
                  (run_r == RUN_TX) ? (mode_r == MODE_SEQ_TX) : (mode_r == MODE_SEQ_RX),
                  "sequencing mode does not match the run")
  `TRS_ASSERT_NEXT(a_decode_resets_read, ctrl.op == UOP_DECODE, rd_r == '0,
                   "read pointer not rewound at decode")

endmodule

@@ src/tx_rx_relay_sequencer.sv @@
// TX/RX relay sequencer for a PTT-keyed amplifier.
// Input channel (in_valid/in_stall/in_data): one word per millisecond tick or
// event (PTT assert/release, fault, fault clear), with the live PTT level.
// Result channel (out_valid/out_stall/out_data): one word per relay write the
// item causes, in order, or a single status word with relay_valid low; the
// final word of an item has last set. Mode and latched fault show the state
// after the whole item.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
// only while no item is in flight.
// Timing: a microcoded sequencer handles one item at a time. An item produces
// 1 to 9 words; each relay step runs through the ADV_STEP and then the
// ADV_TEST microcode step. The next item is accepted once the last word is
// in the output register.
// A stalled receiver holds the output register and freezes the sequencer in
// its emit step.
// Reset: mode RX, no fault, no run, all config registers zero.
module tx_rx_relay_sequencer
  import trs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  trs_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output trs_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  trs_ctrl_t ctrl;
  trs_stat_t stat;

  assign cfg_ready = 1'b1;

  trs_ucode u_ucode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  trs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule
